>>> rtl/modexp_pkg.sv
// shared state codes, product target codes and constants for the modular exponentiation block
package modexp_pkg;

  typedef logic [1:0] state_t;
  typedef logic [1:0] target_t;

  localparam state_t S_IDLE = 2'd0;
  localparam state_t S_MUL  = 2'd1;
  localparam state_t S_BIT  = 2'd2;
  localparam state_t S_DONE = 2'd3;

  // where a finished modular product is written
  localparam target_t TGT_BASE = 2'd0;
  localparam target_t TGT_ACC  = 2'd1;
  localparam target_t TGT_SQR  = 2'd2;

  localparam int MOD_RESET = 23;
  localparam int MOD_REG_INDEX = 0;

endpackage

>>> rtl/modular_exponentiation.sv
// modular exponentiation by right-to-left square and multiply over a shared modular step unit
//
// input beats on s_axis carry a base and an exponent; each gives one output beat on m_axis
// holding base ^ exponent mod modulus. the modulus is written over the apb port at address 0
// and resets to 23; a zero modulus gives 0, a modulus of one gives 0.
// one shift-and-add modular step unit (double, add, subtract 0, m or 2m) does all the work:
// the base is first reduced in OPERAND_WIDTH steps, then for every exponent bit up to the
// highest set one the accumulator is multiplied (set bits only) and the base squared.
// s_axis_tready_o is high only while the sequencer is idle, one item at a time.
// the result sits in an output register; the next item is taken while it waits, and a
// later result holds in the sequencer until m_axis_tready_i frees the register.
// reset clears the sequencer and the output valid and sets the modulus to 23.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // base_value, exponent
  input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // power_result
  output logic [((OPERAND_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                   pready
);

  localparam int W      = OPERAND_WIDTH;
  localparam int OUT_W  = ((W + 7) / 8) * 8;
  localparam int DATA_W = (W > 32) ? 64 : 32;
  localparam int ADDR_W = (W > 32) ? 4 : 3;
  localparam int ADDR_LSB = (W > 32) ? 3 : 2;
  localparam int CNT_W  = $clog2(W);

  logic [W-1:0]     mod_q;
  state_t           state_q, state_d;
  target_t          tgt_q, tgt_d;
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     e_q, e_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     pa_q, pa_d;
  logic [W-1:0]     pb_q, pb_d;
  logic [W-1:0]     p_q, p_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     out_q, out_d;

  logic             cfg_wr;
  logic             in_fire;
  logic [W-1:0]     in_base;
  logic [W-1:0]     in_exp;
  logic [W-1:0]     addend;
  logic [W+1:0]     sum;
  logic [W+1:0]     m1;
  logic [W+1:0]     m2;
  logic [W+1:0]     step_full;
  logic [W-1:0]     step_res;
  logic             last_step;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[ADDR_W-1:ADDR_LSB] == (ADDR_W-ADDR_LSB)'(MOD_REG_INDEX));
  assign prdata = (paddr[ADDR_W-1:ADDR_LSB] == (ADDR_W-ADDR_LSB)'(MOD_REG_INDEX)) ?
                  DATA_W'(mod_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(MOD_RESET);
    end else if (cfg_wr) begin
      mod_q <= pwdata[W-1:0];
    end
  end

  // shared modular step: p <- (2p + bit*a) mod m, with 2p + a below 3m
  always_comb begin
    addend    = pb_q[W-1] ? pa_q : '0;
    sum       = {1'b0, p_q, 1'b0} + {2'b00, addend};
    m1        = {2'b00, mod_q};
    m2        = {1'b0, mod_q, 1'b0};
    if (sum >= m2) begin
      step_full = sum - m2;
    end else if (sum >= m1) begin
      step_full = sum - m1;
    end else begin
      step_full = sum;
    end
    step_res  = step_full[W-1:0];
  end

  assign last_step       = (cnt_q == CNT_W'(W - 1));
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_base         = s_axis_tdata_i[W-1:0];
  assign in_exp          = s_axis_tdata_i[2*W-1:W];

  // sequencer
  always_comb begin
    state_d     = state_q;
    tgt_d       = tgt_q;
    b_d         = b_q;
    e_d         = e_q;
    acc_d       = acc_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          e_d = in_exp;
          if (mod_q == '0) begin
            acc_d   = '0;
            state_d = S_DONE;
          end else begin
            acc_d   = (mod_q == W'(1)) ? '0 : W'(1);
            pa_d    = W'(1);
            pb_d    = in_base;
            p_d     = '0;
            cnt_d   = '0;
            tgt_d   = TGT_BASE;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        p_d   = step_res;
        pb_d  = {pb_q[W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (last_step) begin
          cnt_d = '0;
          unique case (tgt_q)
            TGT_BASE: begin
              b_d     = step_res;
              state_d = S_BIT;
            end
            TGT_ACC: begin
              acc_d   = step_res;
              pa_d    = b_q;
              pb_d    = b_q;
              p_d     = '0;
              tgt_d   = TGT_SQR;
            end
            default: begin
              b_d     = step_res;
              e_d     = {1'b0, e_q[W-1:1]};
              state_d = S_BIT;
            end
          endcase
        end
      end
      S_BIT: begin
        p_d   = '0;
        cnt_d = '0;
        pb_d  = b_q;
        if (e_q == '0) begin
          state_d = S_DONE;
        end else if (e_q[0]) begin
          pa_d    = acc_q;
          tgt_d   = TGT_ACC;
          state_d = S_MUL;
        end else begin
          pa_d    = b_q;
          tgt_d   = TGT_SQR;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      tgt_q       <= TGT_BASE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      tgt_q       <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    p_q   <= p_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_q);

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while the sequencer is busy");

  a_partial_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (p_q < mod_q))
    else $error("partial product not reduced");

  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIT) |-> (b_q < mod_q) && (acc_q < mod_q))
    else $error("base or accumulator not reduced");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (mod_q != '0)) |-> (out_q < mod_q))
    else $error("result beat out of range");

endmodule

>>> tb/modular_exponentiation_tb.sv
// self-checking stream testbench for the modular exponentiation block
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int W = 32;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] MOD_ADDR = 3'(4 * MOD_REG_INDEX);

  typedef struct packed {
    logic [W-1:0] modv;
    logic [W-1:0] base;
    logic [W-1:0] expo;
    logic [W-1:0] want;
    logic         typed;
  } vector_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           s_valid = 1'b0;
  logic           s_ready;
  // base_value, exponent
  logic [2*W-1:0] s_data = '0;
  logic           m_valid;
  logic           m_ready = 1'b0;
  // power_result
  logic [W-1:0]   m_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  logic [W-1:0]   pending_powers[$];
  logic [W-1:0]   modulus_now = W'(MOD_RESET);
  int             idle_pct = 34;
  int             error_count = 0;
  int             beats_in = 0;
  int             beats_out = 0;
  int             moduli_written = 0;
  int             quiet_cycles = 0;

  always #5 clk = ~clk;

  modular_exponentiation #(
    .OPERAND_WIDTH(W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  function automatic logic [W-1:0] power_mod(input logic [W-1:0] b, input logic [W-1:0] e,
                                             input logic [W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mw;
    if (m == '0) return '0;
    mw = {32'd0, m};
    acc = 64'd1 % mw;
    sq = {32'd0, b} % mw;
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * sq) % mw;
      sq = (sq * sq) % mw;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic [W-1:0] b, input logic [W-1:0] e,
                           input logic [W-1:0] want);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {e, b};
    do @(posedge clk); while (!s_ready);
    pending_powers.push_back(want);
    beats_in++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MOD_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== value) report_mismatch("modulus readback", prdata, value);
    modulus_now = value;
    moduli_written++;
  endtask

  task automatic run_random(input logic [W-1:0] m, input int count);
    logic [W-1:0] b;
    logic [W-1:0] e;
    drain();
    set_modulus(m);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: b = $urandom;
        1: b = m - W'($urandom_range(1, 3));
        2: b = W'($urandom_range(0, 3));
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: e = $urandom;
        1: e = $urandom >> $urandom_range(16, 31);
        2: e = 32'd1 << $urandom_range(0, 31);
        default: e = $urandom >> $urandom_range(0, 31);
      endcase
      send_item(b, e, power_mod(b, e, m));
    end
  endtask

  always @(posedge clk) m_ready <= ($urandom_range(0, 99) >= idle_pct);

  always @(posedge clk) begin : result_check
    logic [W-1:0] want;
    if (rst_n && m_valid && m_ready) begin
      beats_out++;
      if (pending_powers.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_data, '0);
      end else begin
        want = pending_powers.pop_front();
        if (m_data !== want) report_mismatch("power_result", m_data, want);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending", STALL_LIMIT,
               pending_powers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    vector_t rows[$];
    // reset modulus of 23
    rows.push_back(vector_t'{32'd23, 32'd0, 32'd0, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'd23, 32'd7, 32'd0, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'd23, 32'd0, 32'd5, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd23, 32'd1, 32'hFFFFFFFF, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'd23, 32'd23, 32'd3, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd23, 32'hFFFFFFFF, 32'd1, 32'd0, 1'b0});
    rows.push_back(vector_t'{32'd23, 32'd2, 32'd22, 32'd0, 1'b0});
    rows.push_back(vector_t'{32'd23, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b0});
    rows.push_back(vector_t'{32'd23, 32'd5, 32'h80000000, 32'd0, 1'b0});
    // zero modulus
    rows.push_back(vector_t'{32'd0, 32'd123, 32'd45, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1});
    // unit modulus, zero even for a zero exponent
    rows.push_back(vector_t'{32'd1, 32'd0, 32'd0, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd1, 32'd99, 32'd7, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1});
    // smallest ring
    rows.push_back(vector_t'{32'd2, 32'd3, 32'd0, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'd2, 32'hFFFFFFFE, 32'd5, 32'd0, 1'b1});
    // largest modulus, bases of minus one, zero and others
    rows.push_back(vector_t'{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2, 32'd1, 1'b1});
    rows.push_back(vector_t'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3, 32'd0, 1'b1});
    rows.push_back(vector_t'{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1});
    rows.push_back(vector_t'{32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF, 32'd0, 1'b0});
    rows.push_back(vector_t'{32'hFFFFFFFF, 32'd0, 32'd0, 32'd1, 1'b1});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].modv != modulus_now) begin
        drain();
        set_modulus(rows[i].modv);
      end
      send_item(rows[i].base, rows[i].expo,
                rows[i].typed ? rows[i].want
                              : power_mod(rows[i].base, rows[i].expo, modulus_now));
    end

    run_random(32'hFFFFFFFF, 40);
    run_random(32'hFFFFFFFB, 40);
    run_random($urandom | 32'h80000000, 40);
    idle_pct = 0;
    run_random(W'($urandom_range(2, 1000)), 40);
    idle_pct = 34;
    run_random(W'(MOD_RESET), 40);
    run_random(W'($urandom_range(2, 65535)), 40);
    run_random($urandom, 40);

    drain();
    repeat (40) @(posedge clk);
    if (pending_powers.size() != 0) begin
      report_mismatch("results never delivered", W'(pending_powers.size()), '0);
    end
    $display("%0d operand beats in, %0d result beats out, %0d errors", beats_in, beats_out,
             error_count);
    $display("%0d modulus writes incl. 0, 1, 2 and all ones, random stalls on both sides",
             moduli_written);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
